// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, off while rst_ni is low
`define UNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on clk_i that also holds through reset
`define UNM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/unm_pkg.sv =====
package unm_pkg;

  localparam int unsigned TickW      = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned OpW        = 3;
  localparam int unsigned HandleW    = 8;
  localparam int unsigned CbvW       = 8;
  localparam int unsigned OutDepthDef = 4;

  localparam logic [CbvW-1:0] CBV_RMR   = 8'h01;
  localparam logic [CbvW-1:0] CBV_AWB   = 8'h10;
  localparam logic [CbvW-1:0] CBV_CLEAR = 8'h00;

  localparam logic [TickW-1:0]  RepeatTicksRst  = 16'd150;
  localparam logic [TickW-1:0]  TimeoutTicksRst = 16'd200;
  localparam logic [TickW-1:0]  WaitTicksRst    = 16'd200;
  localparam logic [TickW-1:0]  CycleTicksRst   = 16'd100;
  localparam logic [TickW-1:0]  FastTicksRst    = 16'd2;
  localparam logic [CountW-1:0] FastCountRst    = 8'd3;

  typedef enum logic [2:0] {
    ST_BUS_SLEEP   = 3'd0,
    ST_PREP_SLEEP  = 3'd1,
    ST_READY_SLEEP = 3'd2,
    ST_NORMAL      = 3'd3,
    ST_REPEAT      = 3'd4
  } nm_state_e;

  typedef enum logic [1:0] {
    MD_BUS_SLEEP  = 2'd0,
    MD_PREP_SLEEP = 2'd1,
    MD_NETWORK    = 2'd2
  } nm_mode_e;

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_INIT       = 3'd1,
    OP_DEINIT     = 3'd2,
    OP_REQUEST    = 3'd3,
    OP_RELEASE    = 3'd4,
    OP_PASSIVE    = 3'd5,
    OP_RECEIVE    = 3'd6,
    OP_REPEAT_REQ = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_INIT    = 2'd1,
    STAT_BAD_HANDLE  = 2'd2,
    STAT_NO_NODE_DET = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REPEAT_TICKS  = 3'd0,
    CFG_TIMEOUT_TICKS = 3'd1,
    CFG_WAIT_TICKS    = 3'd2,
    CFG_CYCLE_TICKS   = 3'd3,
    CFG_FAST_TICKS    = 3'd4,
    CFG_FAST_COUNT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ENT_NONE,
    ENT_SLEEP,
    ENT_PREP,
    ENT_READY,
    ENT_NORMAL,
    ENT_REPEAT
  } entry_e;

  typedef struct packed {
    logic [TickW-1:0]  repeat_ticks;
    logic [TickW-1:0]  timeout_ticks;
    logic [TickW-1:0]  wait_ticks;
    logic [TickW-1:0]  cycle_ticks;
    logic [TickW-1:0]  fast_ticks;
    logic [CountW-1:0] fast_count;
  } cfg_t;

  typedef struct packed {
    nm_state_e       state;
    nm_mode_e        mode;
    logic            send;
    logic [CbvW-1:0] cbv;
    logic            reported;
    status_e         status;
    logic            last;
  } res_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
    res_t res0;
    res_t res1;
  } push_t;

  function automatic nm_mode_e mode_of(nm_state_e s);
    nm_mode_e m;
    unique case (s)
      ST_BUS_SLEEP:  m = MD_BUS_SLEEP;
      ST_PREP_SLEEP: m = MD_PREP_SLEEP;
      default:       m = MD_NETWORK;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/unm_cfg.sv =====
module unm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [unm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [unm_pkg::CfgDataW-1:0]  cfg_data_i,
  output unm_pkg::cfg_t                 cfg_o
);
  import unm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REPEAT_TICKS:  cfg_d.repeat_ticks  = cfg_data_i[TickW-1:0];
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[TickW-1:0];
        CFG_WAIT_TICKS:    cfg_d.wait_ticks    = cfg_data_i[TickW-1:0];
        CFG_CYCLE_TICKS:   cfg_d.cycle_ticks   = cfg_data_i[TickW-1:0];
        CFG_FAST_TICKS:    cfg_d.fast_ticks    = cfg_data_i[TickW-1:0];
        CFG_FAST_COUNT:    cfg_d.fast_count    = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_ticks  <= RepeatTicksRst;
      cfg_q.timeout_ticks <= TimeoutTicksRst;
      cfg_q.wait_ticks    <= WaitTicksRst;
      cfg_q.cycle_ticks   <= CycleTicksRst;
      cfg_q.fast_ticks    <= FastTicksRst;
      cfg_q.fast_count    <= FastCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/unm_fsm.sv =====
`include "assert_macros.svh"

module unm_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [unm_pkg::OpW-1:0]      operation_i,
  input  logic [unm_pkg::HandleW-1:0]  network_handle_i,
  input  unm_pkg::cfg_t                cfg_i,
  input  logic                         space_i,
  output unm_pkg::push_t               push_o
);
  import unm_pkg::*;

  logic                item_vld_q, item_vld_d;
  op_e                 op_q;
  logic [HandleW-1:0]  hdl_q;
  logic                proc;

  logic                init_q, init_d;
  nm_state_e           state_q, state_d;
  logic                nreq_q, nreq_d;
  logic                pas_q, pas_d;
  logic                sen_q, sen_d;
  logic [TickW-1:0]    rc_q, rc_d;
  logic [TickW-1:0]    tc_q, tc_d;
  logic [TickW-1:0]    swc_q, swc_d;
  logic [TickW-1:0]    pc_q, pc_d;
  logic [CountW-1:0]   fl_q, fl_d;
  logic [CbvW-1:0]     cb_q, cb_d;

  entry_e              ent;
  logic                s0, s1;
  logic [CbvW-1:0]     b0, b1;
  logic [TickW-1:0]    period;
  status_e             status;
  logic                asleep;
  res_t                res0, res1;

  assign proc       = item_vld_q && space_i;
  assign in_ready_o = !item_vld_q || proc;
  assign item_vld_d = in_valid_i ? 1'b1 : (proc ? 1'b0 : item_vld_q);
  assign asleep     = (state_q == ST_BUS_SLEEP) || (state_q == ST_PREP_SLEEP);

  always_comb begin
    init_d  = init_q;
    state_d = state_q;
    nreq_d  = nreq_q;
    pas_d   = pas_q;
    sen_d   = sen_q;
    rc_d    = rc_q;
    tc_d    = tc_q;
    swc_d   = swc_q;
    pc_d    = pc_q;
    fl_d    = fl_q;
    cb_d    = cb_q;
    ent     = ENT_NONE;
    s0      = 1'b0;
    s1      = 1'b0;
    b0      = CBV_CLEAR;
    b1      = CBV_CLEAR;
    status  = STAT_OK;
    period  = (fl_q != '0) ? cfg_i.fast_ticks : cfg_i.cycle_ticks;

    // item-specific updates, at most one state entry results
    if (op_q == OP_TICK) begin
      if (init_q) begin
        case (state_q)
          ST_REPEAT: begin
            rc_d = rc_q + TickW'(1);
            tc_d = tc_q + TickW'(1);
            pc_d = pc_q + TickW'(1);
            if (pc_d >= period) begin
              if (sen_q && !pas_q) begin
                s0 = 1'b1;
                b0 = cb_q;
              end
              pc_d = '0;
              if (fl_q != '0) fl_d = fl_q - CountW'(1);
            end
            if (rc_d >= cfg_i.repeat_ticks) begin
              pas_d = 1'b0;
              ent   = nreq_q ? ENT_NORMAL : ENT_READY;
            end
          end
          ST_NORMAL, ST_READY_SLEEP: begin
            tc_d = tc_q + TickW'(1);
            pc_d = pc_q + TickW'(1);
            if (pc_d >= cfg_i.cycle_ticks) begin
              if (sen_q && !pas_q) begin
                s0 = 1'b1;
                b0 = cb_q;
              end
              pc_d = '0;
            end
            if (tc_d >= cfg_i.timeout_ticks) begin
              ent = (state_q == ST_NORMAL) ? ENT_REPEAT : ENT_PREP;
            end
          end
          ST_PREP_SLEEP: begin
            swc_d = swc_q + TickW'(1);
            if (swc_d >= cfg_i.wait_ticks) ent = ENT_SLEEP;
          end
          default: ;
        endcase
      end
    end else if (op_q == OP_INIT) begin
      nreq_d = 1'b0;
      pas_d  = 1'b0;
      tc_d   = '0;
      rc_d   = '0;
      swc_d  = '0;
      pc_d   = '0;
      fl_d   = '0;
      sen_d  = 1'b0;
      cb_d   = CBV_CLEAR;
      init_d = 1'b1;
      ent    = ENT_SLEEP;
    end else if (!init_q) begin
      status = STAT_NOT_INIT;
    end else if (op_q == OP_DEINIT) begin
      init_d = 1'b0;
      ent    = ENT_SLEEP;
    end else if (op_q == OP_RECEIVE) begin
      tc_d = '0;
      if (asleep) begin
        pas_d = 1'b1;
        ent   = ENT_REPEAT;
      end
    end else if (hdl_q != '0) begin
      status = STAT_BAD_HANDLE;
    end else if (op_q == OP_REQUEST) begin
      nreq_d = 1'b1;
      pas_d  = 1'b0;
      if (asleep) begin
        cb_d = cb_q | CBV_AWB;
        ent  = ENT_REPEAT;
      end else if (state_q == ST_READY_SLEEP) begin
        ent = ENT_NORMAL;
      end else begin
        tc_d = '0;
      end
    end else if (op_q == OP_RELEASE) begin
      nreq_d = 1'b0;
      if (state_q == ST_NORMAL) ent = ENT_READY;
    end else if (op_q == OP_PASSIVE) begin
      if (asleep) begin
        pas_d = 1'b1;
        ent   = ENT_REPEAT;
      end
    end else begin
      status = STAT_NO_NODE_DET;
    end

    // state entry
    case (ent)
      ENT_REPEAT: begin
        state_d = ST_REPEAT;
        rc_d    = '0;
        tc_d    = '0;
        pc_d    = '0;
        sen_d   = 1'b1;
        fl_d    = cfg_i.fast_count;
        cb_d    = cb_d | CBV_RMR;
        if (!pas_d) begin
          if (s0) begin
            s1 = 1'b1;
            b1 = cb_d;
          end else begin
            s0 = 1'b1;
            b0 = cb_d;
          end
        end
      end
      ENT_NORMAL: begin
        state_d = ST_NORMAL;
        tc_d    = '0;
        pc_d    = '0;
        fl_d    = '0;
        sen_d   = 1'b1;
        cb_d    = cb_d & ~CBV_RMR;
      end
      ENT_READY: begin
        state_d = ST_READY_SLEEP;
        tc_d    = '0;
        fl_d    = '0;
        sen_d   = 1'b1;
        cb_d    = cb_d & ~CBV_RMR;
      end
      ENT_PREP: begin
        state_d = ST_PREP_SLEEP;
        swc_d   = '0;
        sen_d   = 1'b0;
      end
      ENT_SLEEP: begin
        state_d = ST_BUS_SLEEP;
        sen_d   = 1'b0;
        cb_d    = CBV_CLEAR;
      end
      default: ;
    endcase
  end

  always_comb begin
    res0.state    = state_d;
    res0.mode     = mode_of(state_d);
    res0.send     = s0;
    res0.cbv      = b0;
    res0.reported = (ent != ENT_NONE);
    res0.status   = status;
    res0.last     = !s1;
    res1          = res0;
    res1.cbv      = b1;
    res1.last     = 1'b1;
  end

  assign push_o.wr0  = proc;
  assign push_o.wr1  = proc && s1;
  assign push_o.res0 = res0;
  assign push_o.res1 = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      init_q     <= 1'b0;
      state_q    <= ST_BUS_SLEEP;
      nreq_q     <= 1'b0;
      pas_q      <= 1'b0;
      sen_q      <= 1'b0;
      rc_q       <= '0;
      tc_q       <= '0;
      swc_q      <= '0;
      pc_q       <= '0;
      fl_q       <= '0;
      cb_q       <= CBV_CLEAR;
    end else begin
      item_vld_q <= item_vld_d;
      if (proc) begin
        init_q  <= init_d;
        state_q <= state_d;
        nreq_q  <= nreq_d;
        pas_q   <= pas_d;
        sen_q   <= sen_d;
        rc_q    <= rc_d;
        tc_q    <= tc_d;
        swc_q   <= swc_d;
        pc_q    <= pc_d;
        fl_q    <= fl_d;
        cb_q    <= cb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_e'(operation_i);
      hdl_q <= network_handle_i;
    end
  end

  `UNM_ASSERT(a_second_send_needs_first, push_o.wr1 |-> (push_o.res0.send && push_o.res1.send), "second send without first")
  `UNM_ASSERT_ALWAYS(a_uninit_is_asleep, !init_q |-> (state_q == ST_BUS_SLEEP && cb_q == CBV_CLEAR), "uninitialized but awake")
  `UNM_ASSERT(a_send_status_ok, (push_o.wr0 && push_o.res0.send) |-> (push_o.res0.status == STAT_OK), "send with error status")
  `UNM_ASSERT(a_push_has_space, push_o.wr0 |-> space_i, "push without queue space")

endmodule

// ===== rtl/unm_outq.sv =====
`include "assert_macros.svh"

module unm_outq #(
  parameter int unsigned Depth = unm_pkg::OutDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  unm_pkg::push_t  push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output unm_pkg::res_t   out_res_o
);
  import unm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr_nx;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign space_o     = (count_q <= CntW'(Depth - 2));
  assign wr_nx       = ptr_inc(wr_q);

  always_comb begin
    wr_d = wr_q;
    if (push_i.wr1) begin
      wr_d = ptr_inc(wr_nx);
    end else if (push_i.wr0) begin
      wr_d = wr_nx;
    end
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CntW'(push_i.wr0) + CntW'(push_i.wr1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.wr0) mem_q[wr_q] <= push_i.res0;
    if (push_i.wr1) mem_q[wr_nx] <= push_i.res1;
  end

  `UNM_ASSERT(a_count_bounded, count_q <= CntW'(Depth), "result queue count out of range")
  `UNM_ASSERT(a_pair_fits, push_i.wr1 |-> (count_q <= CntW'(Depth - 2)), "result pair overflows queue")
  `UNM_ASSERT(a_single_push_count, (push_i.wr0 && !push_i.wr1 && !pop) |=> (count_q == $past(count_q) + 1'b1), "queue count slip")

endmodule

// ===== rtl/udp_network_management_fsm_core.sv =====
// One-channel UDP network-management state machine (bus sleep, prepare bus sleep,
// ready sleep, normal operation, repeat message). An accepted beat is held in an
// input register, resolved by combinational next-state logic that updates the
// timers and control bit vector, and its one or two results are written into a
// small result queue (OutDepth entries, at least 2). One item is taken per cycle
// as long as the queue has room for two results; the output side drains one
// result per cycle while out_ready_i is high; an item with two sends gives two
// results. The first result is valid once its beat is written into the queue.
// Six configuration registers are written through cfg_we_i / cfg_index_i /
// cfg_data_i and must only be changed while the block is idle; indexes 6 and 7
// are ignored.
module udp_network_management_fsm_core #(
  parameter int unsigned OutDepth = unm_pkg::OutDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [unm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [unm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [unm_pkg::OpW-1:0]      operation_i,
  input  logic [unm_pkg::HandleW-1:0]  network_handle_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   nm_state_o,
  output logic [1:0]                   nm_mode_o,
  output logic                         send_message_o,
  output logic [unm_pkg::CbvW-1:0]     control_vector_o,
  output logic                         mode_reported_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);
  import unm_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  space;
  res_t  out_res;

  unm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  unm_fsm u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .network_handle_i (network_handle_i),
    .cfg_i            (cfg),
    .space_i          (space),
    .push_o           (push)
  );

  unm_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign nm_state_o       = out_res.state;
  assign nm_mode_o        = out_res.mode;
  assign send_message_o   = out_res.send;
  assign control_vector_o = out_res.cbv;
  assign mode_reported_o  = out_res.reported;
  assign status_o         = out_res.status;
  assign last_o           = out_res.last;

endmodule

// ===== tb/unm_result_checker.sv =====
`timescale 1ns / 1ps

module unm_result_checker
  import unm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [OpW-1:0]      operation_i,
  input  logic [HandleW-1:0]  network_handle_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [2:0]          nm_state_i,
  input  logic [1:0]          nm_mode_i,
  input  logic                send_message_i,
  input  logic [CbvW-1:0]     control_vector_i,
  input  logic                mode_reported_i,
  input  logic [1:0]          status_i,
  input  logic                last_i,
  output int                  results_due_o,
  output int                  mismatches_o
);

  // configured limits
  logic [TickW-1:0]  lim_repeat, lim_timeout, lim_wait, per_cycle, per_fast;
  logic [CountW-1:0] fast_total;

  // predicted machine state
  logic              nm_init, net_req, passive, send_en, mode_flag;
  nm_state_e         cur_state;
  nm_mode_e          cur_mode;
  logic [TickW-1:0]  repeat_cnt, timeout_cnt, wait_cnt, period_cnt;
  logic [CountW-1:0] fast_left;
  logic [CbvW-1:0]   cbv;

  // sends caused by the current beat
  logic [CbvW-1:0]   sent_cbv [2];
  int                sent_n;

  res_t              nm_results_due [$];
  res_t              due, seen;
  int                mismatch_total;

  assign mismatches_o = mismatch_total;

  initial mismatch_total = 0;

  function automatic void nm_try_send();
    if (send_en && !passive && sent_n < 2) begin
      sent_cbv[sent_n] = cbv;
      sent_n++;
    end
  endfunction

  function automatic void nm_enter_repeat();
    cur_state   = ST_REPEAT;
    cur_mode    = MD_NETWORK;
    repeat_cnt  = '0;
    timeout_cnt = '0;
    period_cnt  = '0;
    send_en     = 1'b1;
    fast_left   = fast_total;
    cbv         = cbv | CBV_RMR;
    nm_try_send();
    mode_flag   = 1'b1;
  endfunction

  function automatic void nm_enter_normal();
    cur_state   = ST_NORMAL;
    cur_mode    = MD_NETWORK;
    timeout_cnt = '0;
    period_cnt  = '0;
    fast_left   = '0;
    send_en     = 1'b1;
    cbv         = cbv & ~CBV_RMR;
    mode_flag   = 1'b1;
  endfunction

  function automatic void nm_enter_ready();
    cur_state   = ST_READY_SLEEP;
    cur_mode    = MD_NETWORK;
    timeout_cnt = '0;
    fast_left   = '0;
    send_en     = 1'b1;
    cbv         = cbv & ~CBV_RMR;
    mode_flag   = 1'b1;
  endfunction

  function automatic void nm_enter_prepare();
    cur_state = ST_PREP_SLEEP;
    cur_mode  = MD_PREP_SLEEP;
    wait_cnt  = '0;
    send_en   = 1'b0;
    mode_flag = 1'b1;
  endfunction

  function automatic void nm_enter_sleep();
    cur_state = ST_BUS_SLEEP;
    cur_mode  = MD_BUS_SLEEP;
    send_en   = 1'b0;
    cbv       = CBV_CLEAR;
    mode_flag = 1'b1;
  endfunction

  function automatic void nm_tick();
    logic [TickW-1:0] period;
    case (cur_state)
      ST_REPEAT: begin
        repeat_cnt  = repeat_cnt + 16'd1;
        timeout_cnt = timeout_cnt + 16'd1;
        period_cnt  = period_cnt + 16'd1;
        period = (fast_left != 0) ? per_fast : per_cycle;
        if (period_cnt >= period) begin
          nm_try_send();
          period_cnt = '0;
          if (fast_left != 0) fast_left = fast_left - 8'd1;
        end
        if (repeat_cnt >= lim_repeat) begin
          passive = 1'b0;
          if (net_req) nm_enter_normal();
          else nm_enter_ready();
        end
      end
      ST_NORMAL: begin
        timeout_cnt = timeout_cnt + 16'd1;
        period_cnt  = period_cnt + 16'd1;
        if (period_cnt >= per_cycle) begin
          nm_try_send();
          period_cnt = '0;
        end
        if (timeout_cnt >= lim_timeout) nm_enter_repeat();
      end
      ST_READY_SLEEP: begin
        timeout_cnt = timeout_cnt + 16'd1;
        period_cnt  = period_cnt + 16'd1;
        if (period_cnt >= per_cycle) begin
          nm_try_send();
          period_cnt = '0;
        end
        if (timeout_cnt >= lim_timeout) nm_enter_prepare();
      end
      ST_PREP_SLEEP: begin
        wait_cnt = wait_cnt + 16'd1;
        if (wait_cnt >= lim_wait) nm_enter_sleep();
      end
      default: ;
    endcase
  endfunction

  function automatic void nm_predict(input op_e op, input logic [HandleW-1:0] handle);
    status_e stat;
    res_t    r;
    int      n;
    stat      = STAT_OK;
    sent_n    = 0;
    mode_flag = 1'b0;
    if (op == OP_TICK) begin
      if (nm_init) nm_tick();
    end else if (op == OP_INIT) begin
      net_req     = 1'b0;
      passive     = 1'b0;
      timeout_cnt = '0;
      repeat_cnt  = '0;
      wait_cnt    = '0;
      period_cnt  = '0;
      fast_left   = '0;
      send_en     = 1'b0;
      cbv         = CBV_CLEAR;
      nm_init     = 1'b1;
      nm_enter_sleep();
    end else if (!nm_init) begin
      stat = STAT_NOT_INIT;
    end else if (op == OP_DEINIT) begin
      nm_init = 1'b0;
      nm_enter_sleep();
    end else if (op == OP_RECEIVE) begin
      timeout_cnt = '0;
      if (cur_state == ST_BUS_SLEEP || cur_state == ST_PREP_SLEEP) begin
        passive = 1'b1;
        nm_enter_repeat();
      end
    end else if (handle != '0) begin
      stat = STAT_BAD_HANDLE;
    end else if (op == OP_REQUEST) begin
      net_req = 1'b1;
      passive = 1'b0;
      if (cur_state == ST_BUS_SLEEP || cur_state == ST_PREP_SLEEP) begin
        cbv = cbv | CBV_AWB;
        nm_enter_repeat();
      end else if (cur_state == ST_READY_SLEEP) begin
        nm_enter_normal();
      end else begin
        timeout_cnt = '0;
      end
    end else if (op == OP_RELEASE) begin
      net_req = 1'b0;
      if (cur_state == ST_NORMAL) nm_enter_ready();
    end else if (op == OP_PASSIVE) begin
      if (cur_state == ST_BUS_SLEEP || cur_state == ST_PREP_SLEEP) begin
        passive = 1'b1;
        nm_enter_repeat();
      end
    end else begin
      stat = STAT_NO_NODE_DET;
    end

    n = (sent_n > 0) ? sent_n : 1;
    for (int k = 0; k < n; k++) begin
      r.state    = cur_state;
      r.mode     = cur_mode;
      r.send     = (sent_n > 0);
      r.cbv      = (sent_n > 0) ? sent_cbv[k] : '0;
      r.reported = mode_flag;
      r.status   = stat;
      r.last     = (k == n - 1);
      nm_results_due.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_repeat  = RepeatTicksRst;
      lim_timeout = TimeoutTicksRst;
      lim_wait    = WaitTicksRst;
      per_cycle   = CycleTicksRst;
      per_fast    = FastTicksRst;
      fast_total  = FastCountRst;
      nm_init     = 1'b0;
      net_req     = 1'b0;
      passive     = 1'b0;
      send_en     = 1'b0;
      cur_state   = ST_BUS_SLEEP;
      cur_mode    = MD_BUS_SLEEP;
      fast_left   = '0;
      cbv         = '0;
      repeat_cnt  = '0;
      timeout_cnt = '0;
      wait_cnt    = '0;
      period_cnt  = '0;
      nm_results_due.delete();
      results_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_REPEAT_TICKS:  lim_repeat  = cfg_data_i;
          CFG_TIMEOUT_TICKS: lim_timeout = cfg_data_i;
          CFG_WAIT_TICKS:    lim_wait    = cfg_data_i;
          CFG_CYCLE_TICKS:   per_cycle   = cfg_data_i;
          CFG_FAST_TICKS:    per_fast    = cfg_data_i;
          CFG_FAST_COUNT:    fast_total  = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) nm_predict(op_e'(operation_i), network_handle_i);

      if (out_valid_i && out_ready_i) begin
        seen.state    = nm_state_e'(nm_state_i);
        seen.mode     = nm_mode_e'(nm_mode_i);
        seen.send     = send_message_i;
        seen.cbv      = control_vector_i;
        seen.reported = mode_reported_i;
        seen.status   = status_e'(status_i);
        seen.last     = last_i;
        if (nm_results_due.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: unexpected result st=%0d md=%0d snd=%0b cbv=%02h rep=%0b stat=%0d last=%0b",
                     $realtime, seen.state, seen.mode, seen.send, seen.cbv, seen.reported,
                     seen.status, seen.last);
          mismatch_total++;
        end else begin
          due = nm_results_due.pop_front();
          if (seen.state !== due.state || seen.mode !== due.mode ||
              seen.send !== due.send || seen.cbv !== due.cbv ||
              seen.reported !== due.reported || seen.status !== due.status ||
              seen.last !== due.last) begin
            if (mismatch_total < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  exp st=%0d md=%0d snd=%0b cbv=%02h rep=%0b stat=%0d last=%0b",
                       due.state, due.mode, due.send, due.cbv, due.reported, due.status,
                       due.last);
              $display("  got st=%0d md=%0d snd=%0b cbv=%02h rep=%0b stat=%0d last=%0b",
                       seen.state, seen.mode, seen.send, seen.cbv, seen.reported,
                       seen.status, seen.last);
            end
            mismatch_total++;
          end
        end
      end

      results_due_o <= nm_results_due.size();
    end
  end

endmodule

// ===== tb/tb_udp_network_management_fsm_core.sv =====
`timescale 1ns / 1ps

module tb_udp_network_management_fsm_core;
  import unm_pkg::*;

  localparam int NumPhases     = 12;
  localparam int ItemsPerPhase = 120;
  localparam int DrainCycles   = 4;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index      = '0;
  logic [CfgDataW-1:0] cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [OpW-1:0]      operation      = '0;
  logic [HandleW-1:0]  network_handle = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [2:0]          nm_state;
  logic [1:0]          nm_mode;
  logic                send_message;
  logic [CbvW-1:0]     control_vector;
  logic                mode_reported;
  logic [1:0]          status;
  logic                last;
  int                  results_due;
  int                  mismatch_count;
  int unsigned         quiet_run = 0;

  udp_network_management_fsm_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .network_handle_i (network_handle),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .nm_state_o       (nm_state),
    .nm_mode_o        (nm_mode),
    .send_message_o   (send_message),
    .control_vector_o (control_vector),
    .mode_reported_o  (mode_reported),
    .status_o         (status),
    .last_o           (last)
  );

  unm_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (operation),
    .network_handle_i (network_handle),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .nm_state_i       (nm_state),
    .nm_mode_i        (nm_mode),
    .send_message_i   (send_message),
    .control_vector_i (control_vector),
    .mode_reported_i  (mode_reported),
    .status_i         (status),
    .last_i           (last),
    .results_due_o    (results_due),
    .mismatches_o     (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // result side stalls
  initial begin
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end
        1: begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk_i);
        end
        default: begin
          out_ready <= ($urandom_range(0, 99) < 70);
          @(posedge clk_i);
        end
      endcase
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_run != 0) begin
      quiet_run--;
      return 0;
    end
    if (r < 5) begin
      quiet_run = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_limit(input int kind);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (kind)
      1: return 16'd1;
      2: return 16'hffff;
      3: return 16'd0;
      default: begin
        if (r == 0) return 16'd1;
        if (r == 1) return 16'hffff;
        return CfgDataW'($urandom_range(1, 12));
      end
    endcase
  endfunction

  task automatic send_beat(input op_e op, input logic [HandleW-1:0] handle);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    network_handle <= handle;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
  endtask

  initial begin
    op_e                dir_ops [$] = '{
      OP_TICK, OP_REQUEST, OP_RELEASE, OP_PASSIVE, OP_RECEIVE, OP_DEINIT, OP_REPEAT_REQ,
      OP_INIT, OP_REPEAT_REQ, OP_REPEAT_REQ, OP_REQUEST, OP_RELEASE, OP_PASSIVE,
      OP_REQUEST, OP_TICK, OP_TICK, OP_RECEIVE, OP_REQUEST, OP_RELEASE,
      OP_INIT, OP_PASSIVE, OP_TICK, OP_TICK, OP_DEINIT, OP_RECEIVE
    };
    logic [HandleW-1:0] dir_handles [$] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'hff, 8'h00, 8'haa, 8'h01, 8'h80, 8'hff,
      8'h00, 8'h00, 8'h00, 8'h55, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h00
    };
    int                 kind;
    int unsigned        r;
    op_e                op;
    logic [HandleW-1:0] handle;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on reset limits
    foreach (dir_ops[i]) send_beat(dir_ops[i], dir_handles[i]);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      kind = (p == 2) ? 1 : (p == 5) ? 2 : (p == 8) ? 3 : 0;
      cfg_write(CFG_REPEAT_TICKS, pick_limit(kind));
      cfg_write(CFG_TIMEOUT_TICKS, pick_limit(kind));
      cfg_write(CFG_WAIT_TICKS, pick_limit(kind));
      cfg_write(CFG_CYCLE_TICKS, pick_limit(kind));
      cfg_write(CFG_FAST_TICKS, pick_limit(kind));
      cfg_write(CFG_FAST_COUNT,
                (kind == 1) ? 16'd0 :
                (kind == 2 || $urandom_range(0, 9) == 0) ? 16'd255 :
                CfgDataW'($urandom_range(0, 6)));
      cfg_we <= 1'b0;
      @(posedge clk_i);

      for (int i = 0; i < ItemsPerPhase; i++) begin
        r = $urandom_range(0, 99);
        if (i == 0) op = OP_INIT;
        else if (r < 50) op = OP_TICK;
        else if (r < 58) op = OP_REQUEST;
        else if (r < 65) op = OP_RELEASE;
        else if (r < 72) op = OP_RECEIVE;
        else if (r < 77) op = OP_PASSIVE;
        else if (r < 82) op = OP_INIT;
        else if (r < 86) op = OP_DEINIT;
        else if (r < 90) op = OP_REPEAT_REQ;
        else op = op_e'($urandom_range(0, 7));
        handle = ($urandom_range(0, 99) < 85) ? '0 : HandleW'($urandom_range(1, 255));
        if (p == 3 && i == 60) wait_drained();
        send_beat(op, handle);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
